FILE: hdl/timestamp_lru_key_cache_top_defines.svh
// Assertion macros for the timestamp LRU key cache.
// Used by timestamp_lru_key_cache_top only.
`ifndef TIMESTAMP_LRU_KEY_CACHE_TOP_DEFINES_SVH
`define TIMESTAMP_LRU_KEY_CACHE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define TLKC_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// Next-cycle implication outside reset
`define TLKC_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

FILE: hdl/tlkc_pkg.sv
// Package for the timestamp LRU key cache: sizes, types and shared structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlkc_pkg;
   localparam int ENTRIES = 128;
   localparam int KEY_BITS = 64;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int NOW_W = 48;
   localparam int AGE_W = 29;
   localparam int SLOT_W = 7;
   localparam int CFG_W = 8;
   localparam logic [CFG_W-1:0] CFG_RESET = 8'd100;
   localparam int USEC_PER_SEC = 1000000;
   localparam logic [0:0] KIND_LOOKUP = 1'b0;
   localparam logic [0:0] KIND_INSERT = 1'b1;

   // one queued command from front to back
   typedef struct packed {
      logic                kind;
      logic [KEY_BITS-1:0] key;
      logic [NOW_W-1:0]    now;
      logic [CNT_W-1:0]    count;
   } cmd_type;
endpackage
`default_nettype wire

FILE: hdl/tlkc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tlkc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: hdl/tlkc_front.sv
// Front end: clamps the slot count and queues one command with the key.
// Depends on tlkc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlkc_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_kind,
   input  wire logic [63:0]            req_lookup_key,
   input  wire logic [47:0]            req_now_us,
   input  wire logic                   csr_we,
   input  wire logic [7:0]             csr_wdata,
   output logic                        q_valid,
   output tlkc_pkg::cmd_type           q_cmd,
   input  wire logic                   q_pop
);
   import tlkc_pkg::*;

   logic [CFG_W-1:0] used_ff;
   logic             full_ff;
   cmd_type          cmd_ff;
   logic [CNT_W-1:0] n;
   logic [CNT_W:0]   cfg_ext;

   // slot count: zero acts as one, too large acts as ENTRIES
   always_comb begin
      cfg_ext = (CNT_W + 1)'(used_ff);
      if (used_ff == '0) n = CNT_W'(1);
      else if (cfg_ext > (CNT_W + 1)'(ENTRIES)) n = CNT_W'(ENTRIES);
      else n = cfg_ext[CNT_W-1:0];
   end

   assign busy = full_ff;
   assign q_valid = full_ff;
   assign q_cmd = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= CFG_RESET;
         full_ff <= 1'b0;
      end else begin
         if (csr_we) used_ff <= csr_wdata;
         if (start && !full_ff) full_ff <= 1'b1;
         else if (q_pop) full_ff <= 1'b0;
      end
   end

   // payload queue entry
   always_ff @(posedge clock) begin
      if (start && !full_ff) begin
         cmd_ff.kind  <= req_kind;
         cmd_ff.key   <= req_lookup_key[KEY_BITS-1:0];
         cmd_ff.now   <= req_now_us;
         cmd_ff.count <= n;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/tlkc_div.sv
// Seconds from a 48-bit microsecond delta: divide by one million through a
// reciprocal multiply, one partial product a cycle. Depends on tlkc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlkc_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire logic [47:0]       dividend,
   output logic                   done,
   output logic [28:0]            quotient
);
   import tlkc_pkg::*;

   // one million is 64 * 15625: drop six bits, then divide a 42-bit value
   localparam int DIV_RED = USEC_PER_SEC / 64;
   localparam int RSH = 56;  // 42 dividend bits + 14 divisor bits
   localparam logic [63:0] RECIP =
      ((64'd1 << RSH) + 64'(DIV_RED) - 64'd1) / 64'(DIV_RED);
   localparam logic [21:0] RECIP_LO = RECIP[21:0];
   localparam logic [21:0] RECIP_HI = {1'b0, RECIP[42:22]};

   logic [20:0] y_lo_ff;
   logic [20:0] y_hi_ff;
   logic [84:0] acc_ff;
   logic [1:0]  step_ff;
   logic        run_ff;
   logic [20:0] op_y;
   logic [21:0] op_m;
   logic [6:0]  sh;
   logic [42:0] pp;
   logic [84:0] pp_sh;

   // operand and weight of each partial product
   always_comb begin
      case (step_ff)
         2'd0: begin
            op_y = y_lo_ff;
            op_m = RECIP_LO;
            sh = 7'd0;
         end
         2'd1: begin
            op_y = y_lo_ff;
            op_m = RECIP_HI;
            sh = 7'd22;
         end
         2'd2: begin
            op_y = y_hi_ff;
            op_m = RECIP_LO;
            sh = 7'd21;
         end
         default: begin
            op_y = y_hi_ff;
            op_m = RECIP_HI;
            sh = 7'd43;
         end
      endcase
   end

   assign pp = 43'(op_y) * 43'(op_m);
   assign pp_sh = 85'(pp) << sh;
   assign quotient = acc_ff[84:56];

   // four accumulate steps, then done for one cycle; quotient holds after
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done <= 1'b0;
      end else begin
         done <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            y_lo_ff <= dividend[26:6];
            y_hi_ff <= dividend[47:27];
            acc_ff <= '0;
            step_ff <= '0;
         end else if (run_ff) begin
            acc_ff <= acc_ff + pp_sh;
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               run_ff <= 1'b0;
               done <= 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: hdl/tlkc_back.sv
// Back end: scans the table, updates entries, produces the result.
// Depends on tlkc_pkg, tlkc_ram and tlkc_div.
`timescale 1ns / 1ps
`default_nettype none
module tlkc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire tlkc_pkg::cmd_type   q_cmd,
   output logic                     q_pop,
   output logic                     rsp_valid,
   output logic                     rsp_hit,
   output logic [28:0]              rsp_age_seconds,
   output logic [6:0]               rsp_slot,
   output logic                     rsp_evicted
);
   import tlkc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_LAST  = 6'b000100,
      ST_WRITE = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff;
   logic [ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0] idx_ff;     // address being presented
   logic [IDX_W-1:0] cmp_ff;     // index whose data is on rd_data
   logic             cmp_ok_ff;
   logic             found_ff;
   logic [IDX_W-1:0] tgt_ff;
   logic [NOW_W-1:0] best_ff;
   logic             empty_ff;
   logic [NOW_W-1:0] delta_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] addr;
   logic             wr_en;
   logic [KEY_BITS-1:0] key_rd;
   logic [NOW_W-1:0] stamp_rd;
   logic             div_go, div_done;
   logic [AGE_W-1:0] quo;

   assign addr = (state_ff == ST_WRITE) ? tgt_ff : idx_ff[IDX_W-1:0];
   assign wr_en = (state_ff == ST_WRITE);
   assign div_go = (state_ff == ST_WRITE) && hit_ff;

   tlkc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_keys (
      .clock(clock), .wr_en(wr_en && cmd_ff.kind == KIND_INSERT), .addr(addr),
      .wr_data(cmd_ff.key), .rd_data(key_rd));
   tlkc_ram #(.WIDTH(NOW_W), .DEPTH(ENTRIES)) u_stamps (
      .clock(clock), .wr_en(wr_en && (cmd_ff.kind == KIND_INSERT || hit_ff)),
      .addr(addr), .wr_data(cmd_ff.now), .rd_data(stamp_rd));
   tlkc_div u_div (.clock(clock), .reset(reset), .go(div_go),
      .dividend(delta_ff), .done(div_done), .quotient(quo));

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (q_valid) state_in = ST_SCAN;
         ST_SCAN:  if (idx_ff == cmd_ff.count) state_in = ST_LAST;
         ST_LAST:  state_in = (cmd_ff.kind == KIND_INSERT || found_ff) ? ST_WRITE : ST_DONE;
         ST_WRITE: state_in = hit_ff ? ST_DIV : ST_DONE;
         ST_DIV:   if (div_done) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid <= (state_ff == ST_DONE);
         if (wr_en && cmd_ff.kind == KIND_INSERT) valid_ff[tgt_ff] <= 1'b1;
      end
   end

   // scan datapath; compare lags the address by the registered RAM read
   always_ff @(posedge clock) begin
      cmp_ok_ff <= 1'b0;
      if (state_ff == ST_IDLE) begin
         cmd_ff <= q_cmd;
         idx_ff <= '0;
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
         hit_ff <= 1'b0;
         tgt_ff <= '0;
      end
      if (state_ff == ST_SCAN) begin
         cmp_ff <= idx_ff[IDX_W-1:0];
         cmp_ok_ff <= (idx_ff != cmd_ff.count);
         if (idx_ff != cmd_ff.count) idx_ff <= idx_ff + CNT_W'(1);
      end
      if (cmp_ok_ff && (state_ff == ST_SCAN || state_ff == ST_LAST)) begin
         if (cmd_ff.kind == KIND_LOOKUP) begin
            if (!found_ff && valid_ff[cmp_ff] && key_rd == cmd_ff.key) begin
               found_ff <= 1'b1;
               tgt_ff <= cmp_ff;
               delta_ff <= (cmd_ff.now >= stamp_rd) ? cmd_ff.now - stamp_rd : '0;
            end
         end else if (!empty_ff) begin
            if (!valid_ff[cmp_ff]) begin
               empty_ff <= 1'b1;
               tgt_ff <= cmp_ff;
            end else if (cmp_ff == '0 || stamp_rd < best_ff) begin
               best_ff <= stamp_rd;
               tgt_ff <= cmp_ff;
            end
         end
      end
      if (state_ff == ST_LAST) hit_ff <= found_ff && cmd_ff.kind == KIND_LOOKUP;
      if (state_ff == ST_DONE) begin
         rsp_hit <= hit_ff;
         rsp_age_seconds <= hit_ff ? quo : '0;
         rsp_slot <= (cmd_ff.kind == KIND_INSERT || hit_ff) ? SLOT_W'(tgt_ff) : '0;
         rsp_evicted <= (cmd_ff.kind == KIND_INSERT) && !empty_ff;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/timestamp_lru_key_cache_top.sv
// Top level of the timestamp LRU key cache.
// Depends on tlkc_pkg, tlkc_front, tlkc_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_lru_key_cache_top_defines.svh"
// Fully associative key table, 128 slots, oldest-stamp replacement.
// Request: drive req_kind (0 lookup, 1 insert), req_lookup_key and req_now_us
// and pulse start while busy is low; the transfer happens on that edge.
// The front holds one queued command, so busy rises after each transfer and
// drops once the back end has taken the command.
// Response: rsp_valid is high for one cycle with rsp_hit, rsp_age_seconds,
// rsp_slot and rsp_evicted. The receiver cannot stall; results are held.
// From the transfer to rsp_valid, for n slots in use: one pass over the
// key and stamp RAM read ports, then a write for an insert or a lookup hit;
// a lookup hit also adds a four-step reciprocal multiply for the seconds.
// csr_we/csr_wdata write entries_in_use (0 acts as 1, above 128 as 128);
// write only while idle.
// Reset (synchronous) clears all valid bits at once and sets the slot count
// to 100; key and stamp RAMs need no clearing.
module timestamp_lru_key_cache_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [63:0] req_lookup_key,
   input  wire logic [47:0] req_now_us,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [28:0]      rsp_age_seconds,
   output logic [6:0]       rsp_slot,
   output logic             rsp_evicted
);
   import tlkc_pkg::*;

   logic    q_valid, q_pop;
   cmd_type q_cmd;

   tlkc_front u_front (.clock, .reset, .start, .busy, .req_kind, .req_lookup_key,
      .req_now_us, .csr_we, .csr_wdata, .q_valid, .q_cmd, .q_pop);
   tlkc_back u_back (.clock, .reset, .q_valid, .q_cmd, .q_pop, .rsp_valid,
      .rsp_hit, .rsp_age_seconds, .rsp_slot, .rsp_evicted);

   `TLKC_ASSERT_NXT(a_busy_after_start, clock, reset, start && !busy, busy)
   `TLKC_ASSERT_IMP(a_hit_only_lookup, clock, reset, rsp_valid && rsp_hit, !rsp_evicted)
   `TLKC_ASSERT_IMP(a_age_zero_miss, clock, reset, rsp_valid && !rsp_hit,
      rsp_age_seconds == '0)
endmodule
`default_nettype wire
